/* hw/rtl/dpsm_pkg.sv */
// ----------------------------------------------------------------------------
// dpsm_pkg: shared types and constants of the dual pattern stream matcher
// Status codes, register map and the hit record passed from each cell.
// ----------------------------------------------------------------------------
package dpsm_pkg;

    // status codes
    localparam logic [2:0] ST_IDLE      = 3'd0;
    localparam logic [2:0] ST_SEARCHING = 3'd1;
    localparam logic [2:0] ST_FIRST     = 3'd2;
    localparam logic [2:0] ST_SECOND    = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND = 3'd4;

    // register map, index = paddr / 8
    localparam logic [1:0] REG_FIRST_PAT  = 2'd0;
    localparam logic [1:0] REG_FIRST_LEN  = 2'd1;
    localparam logic [1:0] REG_SECOND_PAT = 2'd2;
    localparam logic [1:0] REG_SECOND_LEN = 2'd3;

    localparam logic [3:0] LEN_RESET = 4'd2;

    // what one cell reports about the byte it is about to hold
    typedef struct packed {
        logic fill;
        logic eq1;
        logic eq2;
    } t_hit;

    // byte i of a pattern, byte 0 being the earliest
    function automatic logic [7:0] pattern_byte(input logic [63:0] pat,
                                                input logic [2:0]  idx);
        return pat[{idx, 3'b000} +: 8];
    endfunction

endpackage

/* hw/rtl/dpsm_cell.sv */
// ----------------------------------------------------------------------------
// dpsm_cell: one history cell of the matcher
// Holds one byte of the window and its fill flag, takes its neighbour's
// byte on each shift and compares the incoming byte with both patterns.
// ----------------------------------------------------------------------------
module dpsm_cell (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_shift,
    input  logic             i_clear,
    input  logic [7:0]       i_byte,
    input  logic             i_fill,
    input  logic [7:0]       i_want1,
    input  logic [7:0]       i_want2,
    output logic [7:0]       o_byte,
    output logic             o_fill,
    output dpsm_pkg::t_hit   o_hit
);

    logic [7:0] r_byte;
    logic       r_fill;
    logic [7:0] n_byte;
    logic       n_fill;

    // a restart empties the history behind the newest byte
    assign n_byte = i_clear ? 8'd0 : i_byte;
    assign n_fill = i_clear ? 1'b0 : i_fill;

    // compare the byte this cell will hold after the shift
    assign o_hit.fill = n_fill;
    assign o_hit.eq1  = (n_byte == i_want1);
    assign o_hit.eq2  = (n_byte == i_want2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= 1'b0;
        end else if (i_shift) begin
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_byte <= n_byte;
        end
    end

    assign o_byte = r_byte;
    assign o_fill = r_fill;

endmodule

/* hw/rtl/dual_pattern_stream_matcher.sv */
// ----------------------------------------------------------------------------
// dual_pattern_stream_matcher: two-pattern byte string matcher
// Watches a byte stream for either of two configured patterns of up to
// MAX_PATTERN_BYTES bytes ending at the newest byte.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one received byte and a
//   begin_search flag per transaction. Each accepted byte yields exactly one
//   status transaction on the output channel (o_out_valid / i_out_ready).
//   Status: idle, searching, first found, second found, not found after
//   SEARCH_LIMIT bytes. Pattern one wins a tie; a result ends the search
//   and later bytes report idle until the next begin_search.
//   The status is registered at the accepting edge.
//   Throughput is one byte per cycle unless the receiver stalls; the history
//   is a row of MAX_PATTERN_BYTES shift cells and the compare is combinational.
//   If the receiver stalls, the status is held in the output register and
//   o_in_ready drops until it is taken.
//   Reset clears the output valid flag, the search and the fill flags of the
//   history, and loads both pattern lengths with 2 and patterns with zero.
//   Registers are written over the APB port at byte addresses 0, 8, 16, 24.
// ----------------------------------------------------------------------------
module dual_pattern_stream_matcher #(
    parameter int SEARCH_LIMIT      = 128,
    parameter int MAX_PATTERN_BYTES = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // byte input
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_begin_search,
    // status output
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_status,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    localparam int CW = $clog2(SEARCH_LIMIT + 1);

    // configuration registers
    logic [63:0] r_pat1;
    logic [63:0] r_pat2;
    logic [3:0]  r_len1;
    logic [3:0]  r_len2;

    // search control
    logic          r_active;
    logic [CW-1:0] r_cnt;
    logic          n_active;
    logic [CW-1:0] n_cnt;

    // output register
    logic       r_out_valid;
    logic [2:0] r_status;
    logic [2:0] n_status;

    logic accept;
    logic live;
    logic shift;
    logic wr;
    logic [3:0] len1s;
    logic [3:0] len2s;
    logic m1;
    logic m2;

    logic [7:0]     w_byte [MAX_PATTERN_BYTES];
    logic           w_fill [MAX_PATTERN_BYTES];
    dpsm_pkg::t_hit w_hit  [MAX_PATTERN_BYTES];

    assign pready = 1'b1;
    assign wr     = psel & penable & pwrite;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat1 <= 64'd0;
            r_pat2 <= 64'd0;
            r_len1 <= dpsm_pkg::LEN_RESET;
            r_len2 <= dpsm_pkg::LEN_RESET;
        end else if (wr) begin
            case (paddr[4:3])
                dpsm_pkg::REG_FIRST_PAT:  r_pat1 <= pwdata;
                dpsm_pkg::REG_FIRST_LEN:  r_len1 <= pwdata[3:0];
                dpsm_pkg::REG_SECOND_PAT: r_pat2 <= pwdata;
                dpsm_pkg::REG_SECOND_LEN: r_len2 <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    // register reads
    always_comb begin
        case (paddr[4:3])
            dpsm_pkg::REG_FIRST_PAT:  prdata = r_pat1;
            dpsm_pkg::REG_FIRST_LEN:  prdata = {60'd0, r_len1};
            dpsm_pkg::REG_SECOND_PAT: prdata = r_pat2;
            dpsm_pkg::REG_SECOND_LEN: prdata = {60'd0, r_len2};
            default:                  prdata = 64'd0;
        endcase
    end

    // lengths above the window saturate
    assign len1s = (r_len1 > 4'(MAX_PATTERN_BYTES)) ? 4'(MAX_PATTERN_BYTES) : r_len1;
    assign len2s = (r_len2 > 4'(MAX_PATTERN_BYTES)) ? 4'(MAX_PATTERN_BYTES) : r_len2;

    assign o_in_ready = ~r_out_valid | i_out_ready;
    assign accept     = i_in_valid & o_in_ready;
    assign live       = i_begin_search | r_active;
    assign shift      = accept & live;

    // row of history cells, cell k holds the byte of age k
    for (genvar k = 0; k < MAX_PATTERN_BYTES; k++) begin : g_cell
        logic [3:0] idx1;
        logic [3:0] idx2;
        logic [7:0] prev_byte;
        logic       prev_fill;
        logic       clr;

        // pattern byte lined up with this age
        assign idx1 = len1s - 4'(k) - 4'd1;
        assign idx2 = len2s - 4'(k) - 4'd1;

        if (k == 0) begin : g_head
            assign prev_byte = i_rx_byte;
            assign prev_fill = 1'b1;
            assign clr       = 1'b0;
        end else begin : g_body
            assign prev_byte = w_byte[k-1];
            assign prev_fill = w_fill[k-1];
            assign clr       = i_begin_search;
        end

        dpsm_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (shift),
            .i_clear (clr),
            .i_byte  (prev_byte),
            .i_fill  (prev_fill),
            .i_want1 (dpsm_pkg::pattern_byte(r_pat1, idx1[2:0])),
            .i_want2 (dpsm_pkg::pattern_byte(r_pat2, idx2[2:0])),
            .o_byte  (w_byte[k]),
            .o_fill  (w_fill[k]),
            .o_hit   (w_hit[k])
        );
    end

    // a pattern matches when every cell inside its length is filled and equal
    always_comb begin
        m1 = 1'b1;
        m2 = 1'b1;
        for (int k = 0; k < MAX_PATTERN_BYTES; k++) begin
            m1 = m1 & ((4'(k) >= len1s) | (w_hit[k].eq1 & w_hit[k].fill));
            m2 = m2 & ((4'(k) >= len2s) | (w_hit[k].eq2 & w_hit[k].fill));
        end
    end

    // status and next search state
    always_comb begin
        n_cnt    = i_begin_search ? CW'(1) : r_cnt + CW'(1);
        n_active = 1'b0;
        if (!live) begin
            n_status = dpsm_pkg::ST_IDLE;
        end else if (m1) begin
            n_status = dpsm_pkg::ST_FIRST;
        end else if (m2) begin
            n_status = dpsm_pkg::ST_SECOND;
        end else if (n_cnt >= CW'(SEARCH_LIMIT)) begin
            n_status = dpsm_pkg::ST_NOT_FOUND;
        end else begin
            n_status = dpsm_pkg::ST_SEARCHING;
            n_active = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_cnt    <= '0;
        end else if (shift) begin
            r_active <= n_active;
            r_cnt    <= n_cnt;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status <= n_status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;

endmodule

/* hw/rtl/dpsm_checker.sv */
// ----------------------------------------------------------------------------
// dpsm_checker: port-level checks of the dual pattern stream matcher
// Watches the byte and status channels of the top level.
// ----------------------------------------------------------------------------
module dpsm_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input logic       i_begin_search,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [2:0] o_status
);

    // a stalled status transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_status))
        else $error("status changed while stalled");

    // an empty output register never blocks the input
    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input blocked with empty output");

    // a restart always gives a live status on the next cycle
    a_begin_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_begin_search
        |=> o_out_valid && o_status != dpsm_pkg::ST_IDLE)
        else $error("restart did not report a search status");

    // status code stays within the defined set
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_status <= dpsm_pkg::ST_NOT_FOUND)
        else $error("undefined status code");

endmodule

bind dual_pattern_stream_matcher dpsm_checker u_dpsm_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_ready     (o_in_ready),
    .i_begin_search (i_begin_search),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_status       (o_status)
);
